// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the string unescaper.
// Each macro expects a signal named clk and a signal named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/jsu_pkg.sv =====
// Types, character codes and helpers for the JSON string unescaper.
// No dependencies; used by the decode, emit and top-level files and by the bench.
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_HEX     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_NOQUOTE = 3'd2,
    KIND_UNTERM  = 3'd3,
    KIND_BADESC  = 3'd4,
    KIND_BADHEX  = 3'd5
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0c;
  localparam logic [7:0] CR_CODE = 8'h0d;

  localparam logic [15:0] CP_MAX1 = 16'h007f;
  localparam logic [15:0] CP_MAX2 = 16'h07ff;
  localparam logic [7:0]  LEAD2   = 8'hc0;
  localparam logic [7:0]  LEAD3   = 8'he0;
  localparam logic [7:0]  CONT    = 8'h80;
  localparam logic [5:0]  CONT_MASK = 6'h3f;

  localparam int MAX_RESULTS = 3;

  // Results caused by one input byte.
  typedef struct packed {
    logic [1:0]                    count;
    kind_t                         kind;
    logic [MAX_RESULTS-1:0][7:0]   bytes;
  } group_t;

  // Bit 4 set marks a byte that is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

// ===== hdl/jsu_if.sv =====
// Valid/ready channel interfaces for the JSON string unescaper.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] result_kind;
  logic       last;

  modport source (output valid, output out_byte, output result_kind, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input result_kind, input last,
                  output ready);
endinterface

// ===== hdl/jsu_decode.sv =====
// Input register, scanner state and one-pass decode of a text byte.
// Depends on jsu_pkg and jsu_if.
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  jsu_in_if.sink          text,
  input  logic            accept_comments,
  input  logic            group_ready,
  output logic            group_load,
  output jsu_pkg::group_t group
);

  logic             in_valid;
  logic [7:0]       in_byte;
  jsu_pkg::mode_t   mode;
  jsu_pkg::mode_t   mode_next;
  logic [11:0]      hex_value;
  logic [11:0]      hex_value_next;
  logic [1:0]       hex_count;
  logic [1:0]       hex_count_next;
  logic [4:0]       digit;
  logic [15:0]      cp;

  assign text.ready = !in_valid || group_ready;
  assign group_load = in_valid && group_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_valid <= 1'b1;
    end else if (group_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jsu_pkg::MODE_IDLE;
      hex_value <= '0;
      hex_count <= '0;
    end else if (group_load) begin
      mode      <= mode_next;
      hex_value <= hex_value_next;
      hex_count <= hex_count_next;
    end
  end

  assign digit = jsu_pkg::hex_digit(in_byte);
  assign cp    = {hex_value, digit[3:0]};

  always_comb begin
    mode_next      = mode;
    hex_value_next = hex_value;
    hex_count_next = hex_count;
    group          = '0;
    group.kind     = jsu_pkg::KIND_BYTE;
    case (mode)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_TAB, jsu_pkg::CH_LF}) begin
          mode_next = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_HASH && accept_comments) begin
          mode_next = jsu_pkg::MODE_COMMENT;
        end else if (in_byte == jsu_pkg::CH_QUOTE) begin
          mode_next = jsu_pkg::MODE_STRING;
        end else begin
          group.count = 2'd1;
          group.kind  = jsu_pkg::KIND_NOQUOTE;
        end
      end
      jsu_pkg::MODE_COMMENT: begin
        if (in_byte == jsu_pkg::CH_LF) begin
          mode_next = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_NUL) begin
          group.count = 2'd1;
          group.kind  = jsu_pkg::KIND_NOQUOTE;
          mode_next   = jsu_pkg::MODE_IDLE;
        end
      end
      jsu_pkg::MODE_STRING: begin
        if (in_byte == jsu_pkg::CH_NUL) begin
          group.count = 2'd1;
          group.kind  = jsu_pkg::KIND_UNTERM;
          mode_next   = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_QUOTE) begin
          group.count = 2'd1;
          group.kind  = jsu_pkg::KIND_DONE;
          mode_next   = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          mode_next = jsu_pkg::MODE_ESCAPE;
        end else begin
          group.count    = 2'd1;
          group.bytes[0] = in_byte;
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        group.count = 2'd1;
        mode_next   = jsu_pkg::MODE_STRING;
        case (in_byte)
          jsu_pkg::CH_QUOTE:  group.bytes[0] = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSLASH: group.bytes[0] = jsu_pkg::CH_BSLASH;
          jsu_pkg::CH_SLASH:  group.bytes[0] = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_B:      group.bytes[0] = jsu_pkg::BS_CODE;
          jsu_pkg::CH_F:      group.bytes[0] = jsu_pkg::FF_CODE;
          jsu_pkg::CH_N:      group.bytes[0] = jsu_pkg::CH_LF;
          jsu_pkg::CH_R:      group.bytes[0] = jsu_pkg::CR_CODE;
          jsu_pkg::CH_T:      group.bytes[0] = jsu_pkg::CH_TAB;
          jsu_pkg::CH_U: begin
            group.count    = 2'd0;
            mode_next      = jsu_pkg::MODE_HEX;
            hex_value_next = '0;
            hex_count_next = '0;
          end
          default: begin
            group.kind = jsu_pkg::KIND_BADESC;
            mode_next  = jsu_pkg::MODE_IDLE;
          end
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (digit[4]) begin
          group.count    = 2'd1;
          group.kind     = jsu_pkg::KIND_BADHEX;
          mode_next      = jsu_pkg::MODE_IDLE;
          hex_value_next = '0;
          hex_count_next = '0;
        end else if (hex_count != 2'd3) begin
          hex_value_next = cp[11:0];
          hex_count_next = hex_count + 2'd1;
        end else begin
          if (cp <= jsu_pkg::CP_MAX1) begin
            group.count    = 2'd1;
            group.bytes[0] = cp[7:0];
          end else if (cp <= jsu_pkg::CP_MAX2) begin
            group.count    = 2'd2;
            group.bytes[0] = jsu_pkg::LEAD2 | {3'b000, cp[10:6]};
            group.bytes[1] = jsu_pkg::CONT | {2'b00, cp[5:0] & jsu_pkg::CONT_MASK};
          end else begin
            group.count    = 2'd3;
            group.bytes[0] = jsu_pkg::LEAD3 | {4'h0, cp[15:12]};
            group.bytes[1] = jsu_pkg::CONT | {2'b00, cp[11:6] & jsu_pkg::CONT_MASK};
            group.bytes[2] = jsu_pkg::CONT | {2'b00, cp[5:0] & jsu_pkg::CONT_MASK};
          end
          hex_value_next = '0;
          hex_count_next = '0;
          mode_next      = jsu_pkg::MODE_STRING;
        end
      end
      default: begin
        mode_next = jsu_pkg::MODE_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/jsu_emit.sv =====
// Result register that holds one decoded group and hands it out one result
// per transaction. Depends on jsu_pkg and jsu_if.
module jsu_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            group_load,
  input  jsu_pkg::group_t group,
  output logic            group_ready,
  jsu_out_if.source       result
);

  logic [1:0]                            count;
  logic [1:0]                            idx;
  jsu_pkg::kind_t                        kind;
  logic [jsu_pkg::MAX_RESULTS-1:0][7:0]  bytes;
  logic                                  at_last;

  assign at_last            = (idx == count - 2'd1);
  assign result.valid       = (count != 2'd0);
  assign result.out_byte    = bytes[idx];
  assign result.result_kind = kind;
  assign result.last        = at_last;
  assign group_ready        = (count == 2'd0) || (result.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (group_load) begin
      count <= group.count;
      idx   <= '0;
    end else if (result.valid && result.ready) begin
      if (at_last) begin
        count <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (group_load) begin
      kind  <= group.kind;
      bytes <= group.bytes;
    end
  end

endmodule

// ===== hdl/json_string_unescape.sv =====
// Top level of the JSON string unescaper: config register, decode, emit.
// Depends on jsu_pkg, jsu_if, jsu_decode, jsu_emit and assert_macros.svh.
//
//   channel   dir   payload                         transaction
//   text      in    data_byte[7:0]                  valid & ready
//   result    out   out_byte[7:0], result_kind, last valid & ready
//   cfg       in    cfg_wr_data (accept_comments)   cfg_wr_en
//
// One text byte per cycle while result is ready; a byte giving no result or one result then never stalls.
// A unicode escape giving two or three bytes holds text ready low while the
// result register hands them out.
// A text byte passes the input register and then the result register before its first result shows.
// Reset clears the state, the input register and the result register.
// A stalled result back-pressures text after one more byte.
`include "assert_macros.svh"

module json_string_unescape (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic            accept_comments;
  logic            group_ready;
  logic            group_load;
  jsu_pkg::group_t group;

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_comments <= 1'b0;
    end else if (cfg_wr_en) begin
      accept_comments <= cfg_wr_data;
    end
  end

  jsu_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .text            (text),
    .accept_comments (accept_comments),
    .group_ready     (group_ready),
    .group_load      (group_load),
    .group           (group)
  );

  jsu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .group_load  (group_load),
    .group       (group),
    .group_ready (group_ready),
    .result      (result)
  );

  `ASSERT_NEXT(a_load_shows, group_load && group.count != 2'd0, result.valid)
  `ASSERT_NEXT(a_last_drains, result.valid && result.ready && result.last && !group_load, !result.valid)
  `ASSERT_IMPL(a_three_byte_lead, group_load && group.count == 2'd3, group.bytes[0][7:4] == 4'he && group.kind == jsu_pkg::KIND_BYTE)

endmodule

// ===== bench/jsu_checker.sv =====
// Scoreboard for the JSON string unescaper: watches the text, result and config ports.
// Predicts the results of every accepted text byte and compares them in order.
// Depends on jsu_pkg and jsu_if.
module jsu_checker
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  jsu_in_if    text,
  jsu_out_if   result,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last;
  } decoded_t;

  decoded_t   expected_q[$];
  decoded_t   batch[$];
  mode_t      state;
  logic       comments_on;
  logic [15:0] hex_value;
  logic [1:0]  hex_count;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  task automatic add_result(input logic [7:0] b, input kind_t k);
    decoded_t d;
    d.out_byte = b;
    d.kind     = k;
    d.last     = 1'b0;
    batch.push_back(d);
  endtask

  task automatic decode_byte(input logic [7:0] c);
    logic [4:0]  digit;
    logic [15:0] cp;
    batch.delete();
    case (state)
      MODE_IDLE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
        end else if (c == CH_HASH && comments_on) begin
          state = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
          state = MODE_STRING;
        end else begin
          add_result(8'h00, KIND_NOQUOTE);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF) begin
          state = MODE_IDLE;
        end else if (c == CH_NUL) begin
          add_result(8'h00, KIND_NOQUOTE);
          state = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          add_result(8'h00, KIND_UNTERM);
          state = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          add_result(8'h00, KIND_DONE);
          state = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          state = MODE_ESCAPE;
        end else begin
          add_result(c, KIND_BYTE);
        end
      end
      MODE_ESCAPE: begin
        state = MODE_STRING;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(c, KIND_BYTE);
          CH_B: add_result(BS_CODE, KIND_BYTE);
          CH_F: add_result(FF_CODE, KIND_BYTE);
          CH_N: add_result(CH_LF, KIND_BYTE);
          CH_R: add_result(CR_CODE, KIND_BYTE);
          CH_T: add_result(CH_TAB, KIND_BYTE);
          CH_U: begin
            state     = MODE_HEX;
            hex_value = '0;
            hex_count = '0;
          end
          default: begin
            add_result(8'h00, KIND_BADESC);
            state = MODE_IDLE;
          end
        endcase
      end
      MODE_HEX: begin
        digit = nibble_of(c);
        if (digit[4]) begin
          add_result(8'h00, KIND_BADHEX);
          state     = MODE_IDLE;
          hex_value = '0;
          hex_count = '0;
        end else if (hex_count != 2'd3) begin
          hex_value = {hex_value[11:0], digit[3:0]};
          hex_count = hex_count + 2'd1;
        end else begin
          cp = {hex_value[11:0], digit[3:0]};
          if (cp <= CP_MAX1) begin
            add_result(cp[7:0], KIND_BYTE);
          end else if (cp <= CP_MAX2) begin
            add_result(LEAD2 | {3'b000, cp[10:6]}, KIND_BYTE);
            add_result(CONT | {2'b00, cp[5:0]}, KIND_BYTE);
          end else begin
            add_result(LEAD3 | {4'b0000, cp[15:12]}, KIND_BYTE);
            add_result(CONT | {2'b00, cp[11:6]}, KIND_BYTE);
            add_result(CONT | {2'b00, cp[5:0]}, KIND_BYTE);
          end
          hex_value = '0;
          hex_count = '0;
          state     = MODE_STRING;
        end
      end
      default: state = MODE_IDLE;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endtask

  task automatic check_result();
    decoded_t exp_item;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h kind=%0d last=%0b",
                                result.out_byte, result.result_kind, result.last));
    end else begin
      exp_item = expected_q.pop_front();
      if (result.out_byte !== exp_item.out_byte)
        report_mismatch($sformatf("out_byte got %02h want %02h",
                                  result.out_byte, exp_item.out_byte));
      if (result.result_kind !== exp_item.kind)
        report_mismatch($sformatf("result_kind got %0d want %0d",
                                  result.result_kind, exp_item.kind));
      if (result.last !== exp_item.last)
        report_mismatch($sformatf("last got %0b want %0b", result.last, exp_item.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      state       = MODE_IDLE;
      comments_on = 1'b0;
      hex_value   = '0;
      hex_count   = '0;
    end else begin
      if (result.valid && result.ready) check_result();
      if (text.valid && text.ready) decode_byte(text.data_byte);
      if (cfg_wr_en) comments_on = cfg_wr_data;
    end
    pending = expected_q.size();
  end

endmodule

// ===== bench/tb_json_string_unescape.sv =====
// Top of the JSON string unescaper bench: clock, reset, text stimulus and result stalls.
// Instantiates the block beside jsu_checker and prints the verdict.
// Depends on jsu_pkg, jsu_if, jsu_checker and json_string_unescape.
module tb_json_string_unescape;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int RANDOM_PER_PHASE = 70;
  localparam int HOLD_CYCLES      = 120;
  localparam logic [7:0] DIRECTED [33] = '{
    CH_SPACE, CH_TAB, CH_LF, CH_HASH, "q", CH_NUL, CH_HASH, CH_LF, 8'hff,
    CH_QUOTE, 8'hff, CH_BSLASH, CH_NUL,
    CH_QUOTE, CH_BSLASH, CH_U, "0", "0", "0", "0", CH_NUL,
    CH_QUOTE, CH_BSLASH, CH_U, "F", "f", "F", "f", CH_QUOTE,
    CH_QUOTE, CH_BSLASH, CH_U, CH_NUL
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic hold_req;
  logic comments_set;
  int   fail_count;
  int   pending;
  int   burst_left;
  int   sent_count;

  jsu_in_if  text_ch ();
  jsu_out_if result_ch ();

  json_string_unescape u_top (
    .clk         (clk),
    .rst         (rst),
    .text        (text_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  jsu_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .text        (text_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_ch.valid     <= 1'b1;
    text_ch.data_byte <= b;
    do begin
      @(negedge clk);
      rdy = text_ch.ready;
      @(posedge clk);
    end while (!rdy);
    sent_count++;
  endtask

  // Hold off new text until every predicted result is out, then let the pipe settle.
  task automatic drain();
    text_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_comments(input logic v);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= v;
    comments_set = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] escape_code(input int i);
    case (i)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      7: return CH_T;
      default: return CH_U;
    endcase
  endfunction

  function automatic logic [7:0] bad_escape_byte();
    logic [7:0] b;
    logic       hit;
    if ($urandom_range(0, 3) == 0) return CH_NUL;
    do begin
      b   = 8'($urandom_range(0, 255));
      hit = 1'b0;
      for (int i = 0; i <= 8; i++) if (b == escape_code(i)) hit = 1'b1;
    end while (hit);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return CH_NUL;
    do b = 8'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] random_cp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 'h7f));
      1: return 16'($urandom_range('h80, 'h7ff));
      2: return 16'($urandom_range('h800, 'hffff));
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return CP_MAX1;
          2: return 16'h0080;
          3: return CP_MAX2;
          4: return 16'h0800;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // bad_at picks the digit replaced by a non-hex byte; 4 or more keeps all four digits.
  task automatic send_unicode(input logic [15:0] cp, input int bad_at);
    logic [3:0] nib;
    logic [7:0] ch;
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    for (int k = 0; k < 4; k++) begin
      nib = cp[15 - 4 * k -: 4];
      if (k == bad_at) begin
        send_byte(non_hex_byte());
        return;
      end
      if (nib < 4'd10) ch = "0" + 8'(nib);
      else ch = (($urandom_range(0, 1) == 1) ? "A" : "a") + 8'(nib) - 8'd10;
      send_byte(ch);
    end
  endtask

  task automatic send_comment();
    logic [7:0] b;
    send_byte(CH_HASH);
    repeat ($urandom_range(0, 4)) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
      send_byte(b);
    end
    send_byte(($urandom_range(0, 5) == 0) ? CH_NUL : CH_LF);
  endtask

  task automatic send_element();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      send_byte(plain_byte());
    end else if (sel < 8) begin
      send_byte(CH_BSLASH);
      send_byte(escape_code($urandom_range(0, 7)));
    end else begin
      send_unicode(random_cp(), 4);
    end
  endtask

  task automatic send_document();
    int shape;
    shape = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) send_byte(escape_code(9) == CH_U ?
      (($urandom_range(0, 2) == 0) ? CH_SPACE : ($urandom_range(0, 1) ? CH_TAB : CH_LF)) :
      CH_SPACE);
    if ($urandom_range(0, 3) == 0 && (comments_set || $urandom_range(0, 2) == 0))
      send_comment();
    if (shape == 9) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(CH_QUOTE);
    repeat ($urandom_range(0, 8)) send_element();
    case (shape)
      6: send_byte(CH_NUL);
      7: begin
        send_byte(CH_BSLASH);
        send_byte(bad_escape_byte());
      end
      8: send_unicode(random_cp(), $urandom_range(0, 3));
      default: send_byte(CH_QUOTE);
    endcase
  endtask

  initial begin : sink_side
    int sel;
    int seg;
    int tick;
    logic hold_taken;
    sel        = 0;
    seg        = 0;
    tick       = 0;
    hold_taken = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (seg == 0) begin
        sel = $urandom_range(0, 3);
        seg = $urandom_range(5, 40);
        if (hold_req && !hold_taken) begin
          sel        = 4;
          seg        = HOLD_CYCLES;
          hold_taken = 1'b1;
        end
      end
      seg--;
      case (sel)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 3) != 0);
        2: result_ch.ready <= ($urandom_range(0, 3) == 0);
        3: result_ch.ready <= (tick % 3 != 0);
        default: result_ch.ready <= 1'b0;
      endcase
    end
  end

  initial begin : stimulus
    int target;
    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.data_byte <= 8'h00;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= 1'b0;
    hold_req          <= 1'b0;
    comments_set = 1'b0;
    burst_left   = 0;
    sent_count   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_comments(1'b1);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      write_comments(phase[0]);
      target = sent_count + RANDOM_PER_PHASE;
      while (sent_count < target) begin
        if (phase == 2 && sent_count > target - RANDOM_PER_PHASE + 20) hold_req <= 1'b1;
        send_document();
      end
      drain();
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
